// File: hdl/assert_macros.svh
// assertion macros for the wildcard match rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define WPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpm assertion failed");
// next-cycle implication, checked out of reset
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpm assertion failed");
`else
`define WPM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/wpm_pkg.sv
// shared types and constants for the wildcard match block
`timescale 1ns / 1ps

package wpm_pkg;

  localparam int LETTER_W     = 5;
  localparam int CODE_W       = 8;
  localparam int MASK_CHARS   = 16;
  localparam int LEN_W        = 5;
  localparam int OUT_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int DEF_MAX_MASK = 16;
  localparam int DEF_POS_BITS = 32;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LEN  = 2'd2;

  // mask character codes
  localparam logic [CODE_W-1:0] CODE_WILD         = 8'd0;
  localparam logic [CODE_W-1:0] CODE_LETTER_FIRST = 8'd1;
  localparam logic [CODE_W-1:0] CODE_LETTER_LAST  = 8'd26;

  typedef struct packed {
    logic              shift;
    logic [CODE_W-1:0] code;
  } wpm_cell_ctl_t;

  function automatic logic is_letter_code(input logic [CODE_W-1:0] code);
    return (code >= CODE_LETTER_FIRST) && (code <= CODE_LETTER_LAST);
  endfunction

endpackage

// File: hdl/wildcard_pattern_match_top.sv
// Wildcard pattern matcher over a letter stream, built as a shifting chain of cells.
// Usage:
//   config : write cfg_index/cfg_data with cfg_valid; cfg_ready is always high.
//            index 0 = mask chars 0..7, 1 = mask chars 8..15 (8 bits each,
//            0 wildcard, 1..26 letters a..z), 2 = mask length 1..16.
//            write only while no transaction is in flight.
//   input  : one letter (0..25) per transaction on in_valid/in_stall.
//   output : out_match_start is the text position where the mask matched,
//            one transaction per matching letter, none otherwise.
// A match is registered on out_valid unless the receiver stalls.
// Throughput: one letter per cycle while in_stall is low; the cell chain shifts
// and compares every letter combinationally, and the output register plus one skid
// entry take the result.
// When the receiver stalls, a second pending match fills the skid entry and
// in_stall stays high up to the cycle after out_stall drops.
// Reset clears the window, position counter, fill count and output buffer;
// the mask resets to a single wildcard.
`timescale 1ns / 1ps

module wildcard_pattern_match_top
  import wpm_pkg::*;
#(
  parameter int MAX_MASK = DEF_MAX_MASK,
  parameter int POS_BITS = DEF_POS_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LETTER_W-1:0]   in_text_letter,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      out_match_start
);

  localparam int FILL_W  = $clog2(MAX_MASK + 1);
  localparam int LEN_CAP = (MAX_MASK < MASK_CHARS) ? MAX_MASK : MASK_CHARS;
  localparam int CMP_W   = (FILL_W > LEN_W) ? FILL_W : LEN_W;
  localparam logic [FILL_W-1:0] FILL_MAX = MAX_MASK[FILL_W-1:0];
  localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_CAP[LEN_W-1:0];
  localparam logic [LEN_W-1:0]  LEN_MIN  = 5'd1;

  logic [CFG_DATA_W-1:0] mask_low_r, mask_high_r;
  logic [LEN_W-1:0]      mask_len_r;
  logic [2*CFG_DATA_W-1:0] mask_all;
  logic [LEN_W-1:0]      len_eff;

  logic [POS_BITS-1:0] seen_r, seen_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                accept;

  wpm_cell_ctl_t       cell_ctl  [MAX_MASK];
  logic [LETTER_W-1:0] cell_in   [MAX_MASK];
  logic [LETTER_W-1:0] cell_out  [MAX_MASK];
  logic [MAX_MASK-1:0] cell_hit;

  logic                       push, buf_full;
  logic [POS_BITS-1:0]        start_pos;
  logic [OUT_W+POS_BITS-1:0]  start_ext;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_low_r  <= '0;
      mask_high_r <= '0;
      mask_len_r  <= LEN_MIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MASK_LOW:  mask_low_r  <= cfg_data;
        REG_MASK_HIGH: mask_high_r <= cfg_data;
        REG_MASK_LEN:  mask_len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign mask_all  = {mask_high_r, mask_low_r};

  always_comb begin
    if (mask_len_r == '0) begin
      len_eff = LEN_MIN;
    end else if (mask_len_r > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = mask_len_r;
    end
  end

  assign accept = in_valid && !in_stall;
  assign in_stall = buf_full;

  // cell j compares the letter j places back; it sees mask char len-1-j
  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int j = 0; j < MAX_MASK; j++) begin
      idx = len_eff - LEN_MIN - LEN_W'(j);
      cell_ctl[j].shift = accept;
      if (j < int'(len_eff)) begin
        cell_ctl[j].code = mask_all[CODE_W*idx[3:0] +: CODE_W];
      end else begin
        cell_ctl[j].code = CODE_WILD;
      end
      cell_in[j] = (j == 0) ? in_text_letter : cell_out[(j == 0) ? 0 : j - 1];
    end
  end

  for (genvar g = 0; g < MAX_MASK; g++) begin : g_cell
    wpm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl[g]),
      .letter_in  (cell_in[g]),
      .letter_out (cell_out[g]),
      .hit        (cell_hit[g])
    );
  end

  assign seen_nxt = seen_r + 1'b1;
  assign fill_nxt = (fill_r == FILL_MAX) ? fill_r : fill_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      fill_r <= '0;
    end else if (accept) begin
      seen_r <= seen_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign start_pos = seen_nxt - {{(POS_BITS-LEN_W){1'b0}}, len_eff};
  assign start_ext = {{OUT_W{1'b0}}, start_pos};
  assign push = accept && (&cell_hit) &&
                ({{(CMP_W-FILL_W){1'b0}}, fill_nxt} >= {{(CMP_W-LEN_W){1'b0}}, len_eff});

  wpm_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (start_ext[OUT_W-1:0]),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_match_start)
  );

endmodule

// File: hdl/wpm_cell.sv
// one window cell: holds a text letter and compares the incoming one with its mask code
`timescale 1ns / 1ps

module wpm_cell
  import wpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  wpm_cell_ctl_t       ctl,
  input  logic [LETTER_W-1:0] letter_in,
  output logic [LETTER_W-1:0] letter_out,
  output logic                hit
);

  logic [LETTER_W-1:0] letter_r;
  logic [CODE_W-1:0]   letter_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letter_r <= '0;
    end else if (ctl.shift) begin
      letter_r <= letter_in;
    end
  end

  // compare against the letter this cell takes on the shift
  assign letter_code = {{(CODE_W-LETTER_W){1'b0}}, letter_in} + CODE_LETTER_FIRST;
  assign hit         = !is_letter_code(ctl.code) || (ctl.code == letter_code);
  assign letter_out  = letter_r;

endmodule

// File: hdl/wpm_out_buf.sv
// output register with one skid entry for match positions
`timescale 1ns / 1ps

`include "assert_macros.svh"

module wpm_out_buf
  import wpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [OUT_W-1:0] push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_data
);

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [OUT_W-1:0] skid_data_r, skid_data_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = push_data;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WPM_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `WPM_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, push, !skid_valid_r)
  `WPM_ASSERT_NEXT(a_stalled_push_kept, clk, rst_n, push && out_valid_r && out_stall,
                   skid_valid_r && (skid_data_r == $past(push_data)))

endmodule
